### rtl/core/tteu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tteu_pkg;

    // Fraction digits taken after the seconds field
    localparam int MAX_FRACTION_DIGITS = 6;

    // Character codes
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Result and multiply-add unit widths
    localparam int TS_W      = 59;
    localparam int MAC_A_W   = 25;
    localparam int MAC_B_W   = 20;
    localparam int MAC_R_W   = 64;
    localparam int MAC_SHIFT = 20;

    // Parsed fields of one text item
    typedef struct packed {
        logic        is_null;
        logic        date_ok;
        logic        time_ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [19:0] micro;
        logic [2:0]  frac;
    } t_fields;

    // One finished result item
    typedef struct packed {
        logic            is_null;
        logic [TS_W-1:0] ts;
        logic            date_ok;
        logic            time_ok;
        logic [2:0]      frac;
    } t_result;

    // Weight of each fraction digit in microseconds
    function automatic logic [16:0] frac_weight(input logic [2:0] idx);
        logic [16:0] w;
        case (idx)
            3'd0:    w = 17'd100000;
            3'd1:    w = 17'd10000;
            3'd2:    w = 17'd1000;
            3'd3:    w = 17'd100;
            3'd4:    w = 17'd10;
            3'd5:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tteu_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module tteu_parse
    import tteu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    input  wire logic       i_absent,
    input  wire logic       i_with_time,
    output logic            o_done,
    output t_fields         o_fields
);

    localparam logic [4:0] POS_TIME     = 5'd10;
    localparam logic [4:0] POS_FRAC_DOT = 5'd19;
    localparam logic [4:0] POS_FRAC_END = 5'(19 + MAX_FRACTION_DIGITS);
    localparam logic [4:0] POS_LAST     = 5'd31;
    localparam int FL_DATE = 0;
    localparam int FL_TIME = 1;
    localparam int FL_FRAC = 2;

    logic [4:0]  r_pos,    w_pos;
    logic        r_mode,   w_mode;
    logic [13:0] r_year,   w_year;
    logic [6:0]  r_month,  w_month;
    logic [6:0]  r_day,    w_day;
    logic [6:0]  r_hour,   w_hour;
    logic [6:0]  r_minute, w_minute;
    logic [6:0]  r_second, w_second;
    logic [19:0] r_micro,  w_micro;
    logic [2:0]  r_flags,  w_flags;
    logic [2:0]  r_frac,   w_frac;

    logic        w_dig;
    logic        w_sep;
    logic [3:0]  w_d;
    logic [4:0]  w_q;
    logic [2:0]  w_fidx;
    logic        w_want;
    logic [5:0]  w_len;
    logic        w_date_ok;
    logic        w_time_ok;

    // Advance the field accumulators by one character
    always_comb begin
        w_pos    = r_pos;
        w_mode   = r_mode;
        w_year   = r_year;
        w_month  = r_month;
        w_day    = r_day;
        w_hour   = r_hour;
        w_minute = r_minute;
        w_second = r_second;
        w_micro  = r_micro;
        w_flags  = r_flags;
        w_frac   = r_frac;
        w_want   = 1'b0;
        w_dig    = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
        w_sep    = !w_dig && (i_char != CHAR_NUL);
        w_d      = w_dig ? i_char[3:0] : 4'd0;
        w_q      = r_pos - POS_TIME;
        w_fidx   = 3'(r_pos - 5'd20);

        if (r_pos == 5'd0) begin
            w_mode = i_with_time;
        end

        if (r_pos < POS_TIME) begin
            // date: YYYY?MM?DD
            w_want = (r_pos == 5'd4) || (r_pos == 5'd7);
            if (w_want ? !w_sep : !w_dig) begin
                w_flags[FL_DATE] = 1'b0;
            end
            if (w_dig) begin
                if (r_pos < 5'd4) begin
                    w_year = r_year * 14'd10 + 14'(w_d);
                end else if ((r_pos == 5'd5) || (r_pos == 5'd6)) begin
                    w_month = r_month * 7'd10 + 7'(w_d);
                end else if ((r_pos == 5'd8) || (r_pos == 5'd9)) begin
                    w_day = r_day * 7'd10 + 7'(w_d);
                end
            end
        end else if (r_pos < POS_FRAC_DOT) begin
            // time: ?hh?mm?ss
            w_want = (w_q == 5'd0) || (w_q == 5'd3) || (w_q == 5'd6);
            if (w_want ? !w_sep : !w_dig) begin
                w_flags[FL_TIME] = 1'b0;
            end
            if (w_dig) begin
                if ((w_q == 5'd1) || (w_q == 5'd2)) begin
                    w_hour = r_hour * 7'd10 + 7'(w_d);
                end else if ((w_q == 5'd4) || (w_q == 5'd5)) begin
                    w_minute = r_minute * 7'd10 + 7'(w_d);
                end else if ((w_q == 5'd7) || (w_q == 5'd8)) begin
                    w_second = r_second * 7'd10 + 7'(w_d);
                end
            end
        end else if (r_pos == POS_FRAC_DOT) begin
            if (i_char == CHAR_NUL) begin
                w_flags[FL_FRAC] = 1'b0;
            end
        end else if (r_pos <= POS_FRAC_END) begin
            // fraction digits until the first non-digit
            if (r_flags[FL_FRAC] && w_dig) begin
                w_micro = r_micro + 20'(w_d) * 20'(frac_weight(w_fidx));
                w_frac  = r_frac + 3'd1;
            end else begin
                w_flags[FL_FRAC] = 1'b0;
            end
        end

        if (r_pos != POS_LAST) begin
            w_pos = r_pos + 5'd1;
        end

        w_len     = {1'b0, r_pos} + 6'd1;
        w_date_ok = w_flags[FL_DATE] && (w_len >= 6'd10);
        w_time_ok = w_date_ok && w_mode && w_flags[FL_TIME] && (w_len >= 6'd19);
    end

    // Build the item handed to the conversion sequencer
    always_comb begin
        o_done   = i_accept && (i_absent || i_last);
        o_fields = '0;
        if (i_absent) begin
            o_fields.is_null = 1'b1;
        end else begin
            o_fields.date_ok = w_date_ok;
            o_fields.time_ok = w_time_ok;
            o_fields.year    = w_year;
            o_fields.month   = w_month;
            o_fields.day     = w_day;
            if (w_time_ok) begin
                o_fields.hour   = w_hour;
                o_fields.minute = w_minute;
                o_fields.second = w_second;
                o_fields.micro  = w_micro;
                o_fields.frac   = w_frac;
            end
        end
    end

    // Hold, advance or clear the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && o_done)) begin
            r_pos    <= '0;
            r_mode   <= 1'b0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_micro  <= '0;
            r_flags  <= '1;
            r_frac   <= '0;
        end else if (i_accept) begin
            r_pos    <= w_pos;
            r_mode   <= w_mode;
            r_year   <= w_year;
            r_month  <= w_month;
            r_day    <= w_day;
            r_hour   <= w_hour;
            r_minute <= w_minute;
            r_second <= w_second;
            r_micro  <= w_micro;
            r_flags  <= w_flags;
            r_frac   <= w_frac;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tteu_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module tteu_mac
    import tteu_pkg::*;
(
    input  wire logic signed [MAC_A_W-1:0] i_a,
    input  wire logic        [MAC_B_W-1:0] i_b,
    input  wire logic signed [MAC_R_W-1:0] i_c,
    input  wire logic                      i_sh,
    output logic signed      [MAC_R_W-1:0] o_res
);

    localparam int PROD_W = MAC_A_W + MAC_B_W + 1;

    logic signed [PROD_W-1:0]  w_prod;
    logic signed [MAC_R_W-1:0] w_ext;
    logic signed [MAC_R_W-1:0] w_term;

    // Signed by unsigned product, optionally scaled up, plus addend
    always_comb begin
        w_prod = i_a * $signed({1'b0, i_b});
        w_ext  = MAC_R_W'(w_prod);
        w_term = i_sh ? (w_ext <<< MAC_SHIFT) : w_ext;
        o_res  = i_c + w_term;
    end

endmodule

`default_nettype wire

### rtl/core/tteu_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tteu_seq
    import tteu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_fields i_fields,
    input  wire logic    i_out_free,
    output logic         o_idle,
    output logic         o_load,
    output t_result      o_result
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERA   = 4'd1;
    localparam logic [3:0] ST_YOE   = 4'd2;
    localparam logic [3:0] ST_DOY_T = 4'd3;
    localparam logic [3:0] ST_DOY   = 4'd4;
    localparam logic [3:0] ST_C100  = 4'd5;
    localparam logic [3:0] ST_Y365  = 4'd6;
    localparam logic [3:0] ST_ERA_D = 4'd7;
    localparam logic [3:0] ST_DAYS  = 4'd8;
    localparam logic [3:0] ST_HOUR  = 4'd9;
    localparam logic [3:0] ST_MIN   = 4'd10;
    localparam logic [3:0] ST_XLO   = 4'd11;
    localparam logic [3:0] ST_XHI   = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    // Reciprocals: y/400 = (y*5243)>>21, t/5 = (t*52429)>>18, yoe/100 = (yoe*41)>>12
    localparam logic [MAC_B_W-1:0] B_RECIP_400 = 20'd5243;
    localparam logic [MAC_B_W-1:0] B_RECIP_5   = 20'd52429;
    localparam logic [MAC_B_W-1:0] B_RECIP_100 = 20'd41;
    localparam logic [MAC_B_W-1:0] B_400       = 20'd400;
    localparam logic [MAC_B_W-1:0] B_153       = 20'd153;
    localparam logic [MAC_B_W-1:0] B_365       = 20'd365;
    localparam logic [MAC_B_W-1:0] B_ERA_DAYS  = 20'd146097;
    localparam logic [MAC_B_W-1:0] B_DAY_SEC   = 20'd86400;
    localparam logic [MAC_B_W-1:0] B_HOUR_SEC  = 20'd3600;
    localparam logic [MAC_B_W-1:0] B_MIN_SEC   = 20'd60;
    localparam logic [MAC_B_W-1:0] B_SEC_US    = 20'd1000000;
    localparam logic [MAC_R_W-1:0] DAY_OFFSET  = 64'd719469;

    logic [3:0]                r_state, n_state;
    t_fields                   r_f;
    logic signed [14:0]        r_y;
    logic signed [5:0]         r_era;
    logic [8:0]                r_yoe;
    logic [14:0]               r_t;
    logic signed [18:0]        r_xhi;
    logic signed [MAC_R_W-1:0] r_sum;

    logic signed [MAC_A_W-1:0] w_a;
    logic [MAC_B_W-1:0]        w_b;
    logic signed [MAC_R_W-1:0] w_c;
    logic                      w_sh;
    logic signed [MAC_R_W-1:0] w_res;
    logic signed [5:0]         w_neg_era;
    logic [6:0]                w_mp;
    logic                      w_skip;

    tteu_mac u_mac (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .i_sh  (w_sh),
        .o_res (w_res)
    );

    // Select the operands of the shared multiply-add for each step
    always_comb begin
        w_neg_era = -r_era;
        w_mp      = (r_f.month > 7'd2) ? (r_f.month - 7'd3) : (r_f.month + 7'd9);
        w_a       = '0;
        w_b       = '0;
        w_c       = '0;
        w_sh      = 1'b0;
        case (r_state)
            ST_ERA: begin
                w_a = MAC_A_W'(r_y);
                w_b = B_RECIP_400;
            end
            ST_YOE: begin
                w_a = MAC_A_W'(w_neg_era);
                w_b = B_400;
                w_c = MAC_R_W'(r_y);
            end
            ST_DOY_T: begin
                w_a = $signed(MAC_A_W'(w_mp));
                w_b = B_153;
                w_c = 64'sd2;
            end
            ST_DOY: begin
                w_a = $signed(MAC_A_W'(r_t));
                w_b = B_RECIP_5;
            end
            ST_C100: begin
                w_a = $signed(MAC_A_W'(r_yoe));
                w_b = B_RECIP_100;
            end
            ST_Y365: begin
                w_a = $signed(MAC_A_W'(r_yoe));
                w_b = B_365;
                w_c = r_sum;
            end
            ST_ERA_D: begin
                w_a = MAC_A_W'(r_era);
                w_b = B_ERA_DAYS;
                w_c = r_sum;
            end
            ST_DAYS: begin
                w_a = r_sum[MAC_A_W-1:0];
                w_b = B_DAY_SEC;
                w_c = $signed(MAC_R_W'(r_f.second));
            end
            ST_HOUR: begin
                w_a = $signed(MAC_A_W'(r_f.hour));
                w_b = B_HOUR_SEC;
                w_c = r_sum;
            end
            ST_MIN: begin
                w_a = $signed(MAC_A_W'(r_f.minute));
                w_b = B_MIN_SEC;
                w_c = r_sum;
            end
            ST_XLO: begin
                w_a = $signed(MAC_A_W'(r_sum[MAC_SHIFT-1:0]));
                w_b = B_SEC_US;
                w_c = $signed(MAC_R_W'(r_f.micro));
            end
            ST_XHI: begin
                w_a  = MAC_A_W'(r_xhi);
                w_b  = B_SEC_US;
                w_c  = r_sum;
                w_sh = 1'b1;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // Step through the conversion
    always_comb begin
        w_skip  = i_fields.is_null || !i_fields.date_ok;
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = w_skip ? ST_OUT : ST_ERA;
            ST_ERA:   n_state = ST_YOE;
            ST_YOE:   n_state = ST_DOY_T;
            ST_DOY_T: n_state = ST_DOY;
            ST_DOY:   n_state = ST_C100;
            ST_C100:  n_state = ST_Y365;
            ST_Y365:  n_state = ST_ERA_D;
            ST_ERA_D: n_state = ST_DAYS;
            ST_DAYS:  n_state = ST_HOUR;
            ST_HOUR:  n_state = ST_MIN;
            ST_MIN:   n_state = ST_XLO;
            ST_XLO:   n_state = ST_XHI;
            ST_XHI:   n_state = ST_OUT;
            ST_OUT:   if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture step results
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_f   <= i_fields;
                    r_y   <= $signed({1'b0, i_fields.year}) -
                             ((i_fields.month <= 7'd2) ? 15'sd1 : 15'sd0);
                    r_sum <= '0;
                end
            end
            ST_ERA:   r_era <= r_y[14] ? -6'sd1 : $signed({1'b0, w_res[25:21]});
            ST_YOE:   r_yoe <= w_res[8:0];
            ST_DOY_T: r_t   <= w_res[14:0];
            ST_DOY: begin
                r_sum <= $signed(MAC_R_W'(w_res[29:18]) + MAC_R_W'(r_f.day) +
                                 MAC_R_W'(r_yoe[8:2]) - DAY_OFFSET);
            end
            ST_C100:  r_sum <= r_sum - $signed(MAC_R_W'(w_res[13:12]));
            ST_Y365, ST_ERA_D, ST_DAYS, ST_HOUR, ST_MIN, ST_XHI: r_sum <= w_res;
            ST_XLO: begin
                r_xhi <= r_sum[38:20];
                r_sum <= w_res;
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

    // Drive the finished item
    always_comb begin
        o_idle           = (r_state == ST_IDLE);
        o_load           = (r_state == ST_OUT) && i_out_free;
        o_result.is_null = r_f.is_null;
        o_result.ts      = r_sum[TS_W-1:0];
        o_result.date_ok = r_f.date_ok;
        o_result.time_ok = r_f.time_ok;
        o_result.frac    = r_f.frac;
    end

endmodule

`default_nettype wire

### rtl/core/timestamp_text_to_epoch_us.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses a date or date-time text field (YYYY?MM?DD, optionally ?hh?mm?ss and a
// fraction of up to six digits) arriving one character per item and returns signed
// microseconds since 1970-01-01. Characters are taken one per cycle while the
// sequencer is idle. After the item with tlast (or a null marker in tuser) the block
// drops tready while a small sequencer runs days-from-civil and the scaling to
// microseconds through one shared 25x20-bit multiply-add unit, one step per cycle;
// a null field or an invalid date skips these steps. The result sits in an output
// register, so the next field can start while it waits; tready stays low at the
// end of a second field until the first is taken.
module timestamp_text_to_epoch_us
    import tteu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  wire logic        i_s_axis_tlast,   // last_char
    input  wire logic [1:0]  i_s_axis_tuser,   // [0] field_absent, [1] with_time
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // [58:0] timestamp_us, [59] date_ok,
                                               // [60] time_ok, [63:61] fraction_digits
    output logic [0:0]       o_m_axis_tuser    // [0] is_null
);

    logic    w_in_acc;
    logic    w_done;
    t_fields w_fields;
    logic    w_idle;
    logic    w_load;
    logic    w_out_free;
    t_result w_result;

    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic [0:0]  r_m_user;

    assign o_s_axis_tready = w_idle;
    assign w_in_acc        = i_s_axis_tvalid && w_idle;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;

    tteu_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_acc),
        .i_char      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_absent    (i_s_axis_tuser[0]),
        .i_with_time (i_s_axis_tuser[1]),
        .o_done      (w_done),
        .o_fields    (w_fields)
    );

    tteu_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_done),
        .i_fields   (w_fields),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_load     (w_load),
        .o_result   (w_result)
    );

    // Hold the result item until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= {w_result.frac, w_result.time_ok, w_result.date_ok, w_result.ts};
            r_m_user <= w_result.is_null;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // A closing item starts the conversion, so the input side stalls next cycle
    a_stall_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_s_axis_tlast || i_s_axis_tuser[0])) |=> !o_s_axis_tready)
        else $error("input still ready after closing item");

    // A null result carries nothing else
    a_null_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 64'd0))
        else $error("null result with payload");

    // Time is only added on top of a valid date
    a_time_needs_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[60]) |-> o_m_axis_tdata[59])
        else $error("time_ok without date_ok");

    // An invalid date gives a zero timestamp and no fraction digits
    a_bad_date_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[59]) |->
            ((o_m_axis_tdata[58:0] == 59'd0) && (o_m_axis_tdata[63:61] == 3'd0)))
        else $error("invalid date with nonzero timestamp");

endmodule

`default_nettype wire
